FILE: hdl/cdq_pkg.sv
package cdq_pkg;

  // Storage depth and data width defaults
  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;
  localparam int CAP_W         = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Request codes
  typedef enum logic [1:0] {
    REQ_PUSH_FRONT = 2'd0,
    REQ_PUSH_BACK  = 2'd1,
    REQ_POP_FRONT  = 2'd2,
    REQ_POP_BACK   = 2'd3
  } req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

endpackage

FILE: hdl/cdq_ram.sv
module cdq_ram #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [cdq_pkg::DATA_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [cdq_pkg::DATA_W-1:0] rd_data
);

  logic [cdq_pkg::DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/circular_deque.sv
// Double-ended queue kept in a ring of DEPTH 32-bit entries in one synchronous
// memory. Each request pushes push_value at the front or back, or pops from the
// front or back, and yields one result with a status (ok, full, empty); a
// refused or pushing request returns pop_value zero. The ring size in use is
// set by the capacity register (0 acts as 1, values above DEPTH act as DEPTH);
// write it only while no request is outstanding, it is always ready. A push or
// a refused pop is loaded straight into the result register, so one can be
// taken every cycle while the result register drains. A successful pop goes
// through the registered read port of the ring memory: input stalls during the
// read and the value lands in the result register the cycle after. Input also
// stalls while a result is held by out_stall. Only one memory access is issued
// per cycle, so reads always see every earlier write. No clearing pass needed.
module circular_deque #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic signed [cdq_pkg::DATA_W-1:0] push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [cdq_pkg::DATA_W-1:0] pop_value,
  output logic [1:0]                        status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cdq_pkg::CAP_W-1:0]         cfg_data
);

  localparam int AW  = $clog2(DEPTH);
  localparam int NW  = $clog2(DEPTH + 1);
  localparam int CW  = (NW > cdq_pkg::CAP_W) ? NW : cdq_pkg::CAP_W;

  cdq_pkg::state_t state, state_next;

  logic [cdq_pkg::CAP_W-1:0] capacity;
  logic [AW-1:0]             front_index, front_next;
  logic [AW-1:0]             back_index, back_next;
  logic [NW-1:0]             item_count, count_next;

  logic [CW-1:0] cap_ext, cap_eff, front_inc_n, back_inc_n;
  logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          is_full, is_empty, in_accept, out_accept;

  logic                       wr_en, rd_en;
  logic [AW-1:0]              wr_addr, rd_addr;
  logic [cdq_pkg::DATA_W-1:0] rd_data;

  logic                  res_load;
  cdq_pkg::status_t      res_status;

  // Capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cdq_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Clamp capacity into 1..DEPTH
  always_comb begin
    cap_ext = CW'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end

  // Index wrap by compare against the capacity
  assign front_inc_n = CW'(front_index) + CW'(1);
  assign back_inc_n  = CW'(back_index) + CW'(1);
  assign front_inc   = (front_inc_n >= cap_eff) ? '0 : AW'(front_inc_n);
  assign back_inc    = (back_inc_n >= cap_eff) ? '0 : AW'(back_inc_n);
  assign front_dec   = (front_index == '0) ? AW'(cap_eff - CW'(1)) : front_index - AW'(1);
  assign back_dec    = (back_index == '0) ? AW'(cap_eff - CW'(1)) : back_index - AW'(1);

  assign is_full  = (CW'(item_count) >= cap_eff);
  assign is_empty = (item_count == '0);

  // Handshakes
  assign in_stall   = (state != cdq_pkg::S_IDLE) || (out_valid && out_stall);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Decode request, update pointers, issue at most one memory access
  always_comb begin
    front_next = front_index;
    back_next  = back_index;
    count_next = item_count;
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = back_index;
    rd_en      = 1'b0;
    rd_addr    = front_index;
    res_load   = 1'b0;
    res_status = cdq_pkg::ST_OK;
    unique case (state)
      cdq_pkg::S_IDLE: begin
        if (in_accept) begin
          unique case (cdq_pkg::req_t'(req_type))
            cdq_pkg::REQ_PUSH_FRONT: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = cdq_pkg::ST_FULL;
              end else begin
                front_next = front_dec;
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                count_next = item_count + NW'(1);
              end
            end
            cdq_pkg::REQ_PUSH_BACK: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status = cdq_pkg::ST_FULL;
              end else begin
                back_next  = back_inc;
                wr_en      = 1'b1;
                wr_addr    = back_index;
                count_next = item_count + NW'(1);
              end
            end
            cdq_pkg::REQ_POP_FRONT: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = cdq_pkg::ST_EMPTY;
              end else begin
                front_next = front_inc;
                rd_en      = 1'b1;
                rd_addr    = front_index;
                count_next = item_count - NW'(1);
                state_next = cdq_pkg::S_READ;
              end
            end
            cdq_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                res_load   = 1'b1;
                res_status = cdq_pkg::ST_EMPTY;
              end else begin
                back_next  = back_dec;
                rd_en      = 1'b1;
                rd_addr    = back_dec;
                count_next = item_count - NW'(1);
                state_next = cdq_pkg::S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      cdq_pkg::S_READ: begin
        state_next = cdq_pkg::S_IDLE;
      end
      default: begin
        state_next = cdq_pkg::S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= cdq_pkg::S_IDLE;
      front_index <= '0;
      back_index  <= '0;
      item_count  <= '0;
    end else begin
      state       <= state_next;
      front_index <= front_next;
      back_index  <= back_next;
      item_count  <= count_next;
    end
  end

  // Ring memory
  cdq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(push_value),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load || state == cdq_pkg::S_READ) begin
      out_valid <= 1'b1;
    end else if (out_accept) begin
      out_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (state == cdq_pkg::S_READ) begin
      pop_value <= rd_data;
      status    <= cdq_pkg::ST_OK;
    end else if (res_load) begin
      pop_value <= '0;
      status    <= res_status;
    end
  end

  // Count never passes the storage depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CW'(item_count) <= CW'(DEPTH))
    else $error("item count beyond depth");

  // Result register is free whenever a read completes
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == cdq_pkg::S_READ) |-> !out_valid)
    else $error("read completes into occupied result register");

  // A read is followed by a valid ok result
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    (state == cdq_pkg::S_READ) |=> (out_valid && status == cdq_pkg::ST_OK))
    else $error("pop result missing");

  // Only one memory access per cycle
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("write and read issued together");

endmodule
